// File: rtl/core/apw_pkg.sv
package apw_pkg;

  localparam int unsigned WAVE_LEN    = 128;
  localparam int unsigned IDX_W       = $clog2(WAVE_LEN);
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SUM_W       = 26;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned PROC_W      = 11;
  localparam int unsigned ACC_W       = SAMPLE_BITS + IDX_W;
  localparam int unsigned ADC_W       = 12;
  localparam int unsigned VOLT_W      = 7;
  localparam int unsigned DRIVE_W     = 10;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [SAMPLE_BITS-1:0] AVG_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [PROC_W-1:0]      PED_OFFSET = PROC_W'(100);

  // volt = adc * 17 / 1000, estimated as adc * 17833 >> 20, then corrected down by one where it overshoots
  localparam int unsigned            VOLT_SCALE = 17;
  localparam int unsigned            VOLT_DIV   = 1000;
  localparam int unsigned            VOLT_RECIP = 17833;
  localparam int unsigned            VOLT_SHIFT = 20;
  localparam int unsigned            VPROD_W    = ADC_W + 15;
  localparam logic [VOLT_W-1:0]      VOLT_LO_MIN = VOLT_W'(16);
  localparam logic [VOLT_W-1:0]      VOLT_LO_MAX = VOLT_W'(20);
  localparam logic [VOLT_W-1:0]      VOLT_HI_MAX = VOLT_W'(3);
  localparam logic [DRIVE_W-1:0]     DRIVE_FULL  = DRIVE_W'(1023);

  typedef enum logic [CMD_W-1:0] {
    CMD_PED     = 2'd0,
    CMD_PULSE   = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PED_COUNT   = 2'd0,
    REG_PULSE_COUNT = 2'd1,
    REG_SUBTRACT    = 2'd2,
    REG_DRIVE       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [IDX_W-1:0]       idx;
    logic [SAMPLE_BITS-1:0] val;
    logic [ADC_W-1:0]       adc;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   ped_count;
    logic [CNT_W-1:0]   pulse_count;
    logic               subtract;
    logic [DRIVE_W-1:0] drive;
  } cfg_t;

  typedef struct packed {
    logic [VOLT_W-1:0]      volt;
    logic [SAMPLE_BITS-1:0] base;
    logic [PROC_W-1:0]      amp;
    logic [IDX_W-1:0]       width;
    logic [IDX_W:0]         pos;
    logic                   ok;
  } result_t;

endpackage

// File: rtl/core/apw_front.sv
module apw_front import apw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [SAMPLE_BITS-1:0] val_i,
  input  logic [ADC_W-1:0]       adc_i,
  output logic                   item_vld_o,
  output item_t                  item_o,
  input  logic                   item_take_i
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       acc, keep;

  assign full_o     = (cnt_q == 2'd2);
  assign acc        = push_i && !full_o;
  // drop the unused command here so the back end never sees it
  assign keep       = acc && (cmd_e'(cmd_i) != CMD_NONE);
  assign item_vld_o = (cnt_q != 2'd0);
  assign item_o     = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (keep) begin
      fifo_q[wr_ptr_q] <= '{cmd: cmd_e'(cmd_i), idx: idx_i, val: val_i, adc: adc_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (keep) wr_ptr_q <= !wr_ptr_q;
      if (item_take_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(keep) - 2'(item_take_i);
    end
  end

endmodule

// File: rtl/core/apw_div.sv
module apw_div import apw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [SUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q, dvs_q;
  logic [CNT_W:0]    rem_s, diff;
  logic              fits;

  // one quotient bit per cycle; quotient bits shift in behind the dividend
  assign rem_s  = {rem_q, dvd_q[SUM_W-1]};
  assign diff   = rem_s - {1'b0, dvs_q};
  assign fits   = (rem_s >= {1'b0, dvs_q});
  assign busy_o = busy_q;
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(SUM_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) busy_q <= 1'b0;
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[CNT_W-1:0] : rem_s[CNT_W-1:0];
    end
  end

endmodule

// File: rtl/core/apw_back.sv
module apw_back import apw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_vld_i,
  input  item_t   item_i,
  output logic    item_take_o,
  output logic    res_vld_o,
  output result_t res_o,
  input  logic    res_pop_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_C_RD, ST_C_START, ST_C_WAIT, ST_C_WR,
    ST_BASE, ST_PK_RD, ST_PK_CMP, ST_HALF, ST_HI_RD, ST_HI_CMP, ST_LO_START,
    ST_LO_RD, ST_LO_CMP, ST_VOLT1, ST_VOLT2
  } state_e;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(WAVE_LEN - 1);

  state_e                 state_q;
  cmd_e                   cmd_q;
  logic [IDX_W-1:0]       addr_q, max_q, hi_q, lo_q;
  logic [SAMPLE_BITS-1:0] val_q, base_q;
  logic [ADC_W-1:0]       adc_q;
  logic [ACC_W-1:0]       acc_q;
  logic [PROC_W-1:0]      peak_q, amp_q, half_q;
  logic [VPROD_W-1:0]     vprod_q;
  logic [WAVE_LEN-1:0]    ped_vld_q, pul_vld_q;
  logic                   res_vld_q;
  result_t                res_q;

  logic [SUM_W-1:0]  ped_mem [WAVE_LEN];
  logic [SUM_W-1:0]  pul_mem [WAVE_LEN];
  logic [PROC_W-1:0] proc_mem [WAVE_LEN];
  logic [SUM_W-1:0]  ped_rd_q, pul_rd_q;
  logic [PROC_W-1:0] proc_rd_q;

  logic                   ped_we, pul_we, proc_we;
  logic [SUM_W-1:0]       ped_sum, pul_sum, acc_sum;
  logic [IDX_W-1:0]       proc_wa;
  logic                   div_start, ped_busy, pul_busy;
  logic [SUM_W-1:0]       ped_quot, pul_quot;
  logic [CNT_W-1:0]       ped_dvs, pul_dvs;
  logic [SAMPLE_BITS-1:0] ped_avg, pul_avg;
  logic [PROC_W-1:0]      p_ext, d_ext, proc_wd;
  logic [PROC_W-1:0]      amp_n;
  logic [VOLT_W-1:0]      volt_est, volt;
  logic [ADC_W+4:0]       adc_x17;
  logic [VOLT_W+9:0]      est_x1000;
  logic                   volt_ok, out_free, res_load;

  assign ped_sum = ped_vld_q[addr_q] ? ped_rd_q : '0;
  assign pul_sum = pul_vld_q[addr_q] ? pul_rd_q : '0;
  assign acc_sum = ((cmd_q == CMD_PED) ? ped_sum : pul_sum) + SUM_W'(val_q);
  assign ped_we  = (state_q == ST_ACC_WR) && (cmd_q == CMD_PED);
  assign pul_we  = (state_q == ST_ACC_WR) && (cmd_q == CMD_PULSE);
  assign proc_we = (state_q == ST_C_WR);
  assign proc_wa = LAST - addr_q;

  always_ff @(posedge clk_i) begin
    if (ped_we) ped_mem[addr_q] <= acc_sum;
    ped_rd_q <= ped_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (pul_we) pul_mem[addr_q] <= acc_sum;
    pul_rd_q <= pul_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (proc_we) proc_mem[proc_wa] <= proc_wd;
    proc_rd_q <= proc_mem[addr_q];
  end

  // a count of zero divides as one
  assign ped_dvs   = (cfg_i.ped_count == '0) ? CNT_W'(1) : cfg_i.ped_count;
  assign pul_dvs   = (cfg_i.pulse_count == '0) ? CNT_W'(1) : cfg_i.pulse_count;
  assign div_start = (state_q == ST_C_START);

  apw_div u_ped_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(ped_sum), .divisor_i(ped_dvs),
    .busy_o(ped_busy), .quot_o(ped_quot)
  );

  apw_div u_pul_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(pul_sum), .divisor_i(pul_dvs),
    .busy_o(pul_busy), .quot_o(pul_quot)
  );

  assign ped_avg = (ped_quot[SUM_W-1:SAMPLE_BITS] != '0) ? AVG_MAX
                                                          : ped_quot[SAMPLE_BITS-1:0];
  assign pul_avg = (pul_quot[SUM_W-1:SAMPLE_BITS] != '0) ? AVG_MAX
                                                          : pul_quot[SAMPLE_BITS-1:0];
  assign p_ext   = PROC_W'(pul_avg) + PED_OFFSET;
  assign d_ext   = PROC_W'(ped_avg);
  assign proc_wd = !cfg_i.subtract ? PROC_W'(pul_avg)
                 : (p_ext >= d_ext) ? p_ext - d_ext : '0;

  assign amp_n = (peak_q > PROC_W'(base_q)) ? peak_q - PROC_W'(base_q) : '0;

  assign adc_x17   = (ADC_W+5)'(adc_q) * (ADC_W+5)'(VOLT_SCALE);
  assign volt_est  = vprod_q[VOLT_SHIFT +: VOLT_W];
  assign est_x1000 = (VOLT_W+10)'(volt_est) * (VOLT_W+10)'(VOLT_DIV);
  assign volt      = (est_x1000 > (VOLT_W+10)'(adc_x17)) ? volt_est - 1'b1 : volt_est;
  assign volt_ok   = ((cfg_i.drive == '0) && (volt >= VOLT_LO_MIN) && (volt <= VOLT_LO_MAX))
                  || ((cfg_i.drive == DRIVE_FULL) && (volt <= VOLT_HI_MAX));

  assign out_free    = !res_vld_q || res_pop_i;
  assign res_load    = (state_q == ST_VOLT2) && out_free;
  assign item_take_o = (state_q == ST_IDLE) && item_vld_i;
  assign res_vld_o   = res_vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ped_vld_q <= '0;
      pul_vld_q <= '0;
      res_vld_q <= 1'b0;
      cmd_q     <= CMD_PED;
      addr_q    <= '0;
    end else begin
      if (res_load) res_vld_q <= 1'b1;
      else if (res_pop_i) res_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (item_vld_i) begin
            cmd_q <= item_i.cmd;
            val_q <= item_i.val;
            adc_q <= item_i.adc;
            if (item_i.cmd == CMD_COMPUTE) begin
              addr_q  <= '0;
              acc_q   <= '0;
              state_q <= ST_C_RD;
            end else begin
              addr_q  <= item_i.idx;
              state_q <= ST_ACC_RD;
            end
          end
        end
        ST_ACC_RD: state_q <= ST_ACC_WR;
        ST_ACC_WR: begin
          if (cmd_q == CMD_PED) ped_vld_q[addr_q] <= 1'b1;
          else pul_vld_q[addr_q] <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_C_RD:    state_q <= ST_C_START;
        ST_C_START: state_q <= ST_C_WAIT;
        ST_C_WAIT: begin
          if (!ped_busy && !pul_busy) state_q <= ST_C_WR;
        end
        ST_C_WR: begin
          acc_q <= acc_q + ACC_W'(ped_avg);
          if (addr_q == LAST) begin
            state_q <= ST_BASE;
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= ST_C_RD;
          end
        end
        ST_BASE: begin
          base_q  <= cfg_i.subtract ? PED_OFFSET[SAMPLE_BITS-1:0] : acc_q[ACC_W-1:IDX_W];
          addr_q  <= '0;
          state_q <= ST_PK_RD;
        end
        ST_PK_RD: state_q <= ST_PK_CMP;
        ST_PK_CMP: begin
          if (addr_q == '0 || proc_rd_q > peak_q) begin
            peak_q <= proc_rd_q;
            max_q  <= addr_q;
          end
          if (addr_q == LAST) begin
            state_q <= ST_HALF;
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= ST_PK_RD;
          end
        end
        ST_HALF: begin
          amp_q   <= amp_n;
          half_q  <= (amp_n >> 1) + PROC_W'(base_q);
          addr_q  <= max_q;
          hi_q    <= LAST;
          state_q <= ST_HI_RD;
        end
        ST_HI_RD: state_q <= ST_HI_CMP;
        ST_HI_CMP: begin
          if (proc_rd_q < half_q) begin
            hi_q    <= addr_q;
            state_q <= ST_LO_START;
          end else if (addr_q == LAST) begin
            state_q <= ST_LO_START;
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= ST_HI_RD;
          end
        end
        ST_LO_START: begin
          addr_q  <= max_q;
          lo_q    <= '0;
          state_q <= ST_LO_RD;
        end
        ST_LO_RD: state_q <= ST_LO_CMP;
        ST_LO_CMP: begin
          if (proc_rd_q < half_q) begin
            lo_q    <= addr_q;
            state_q <= ST_VOLT1;
          end else if (addr_q == '0) begin
            state_q <= ST_VOLT1;
          end else begin
            addr_q  <= addr_q - 1'b1;
            state_q <= ST_LO_RD;
          end
        end
        ST_VOLT1: begin
          vprod_q <= VPROD_W'(adc_q) * VPROD_W'(VOLT_RECIP);
          state_q <= ST_VOLT2;
        end
        ST_VOLT2: begin
          if (out_free) begin
            res_q     <= '{volt: volt, base: base_q, amp: amp_q, width: hi_q - lo_q,
                           pos: {1'b0, max_q} + 1'b1, ok: volt_ok};
            ped_vld_q <= '0;
            pul_vld_q <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/pulse_average_peak_width_analyzer.sv
// Channel   Direction  Handshake              Payload
// input     in         push_i / full_o        cmd_i, sample_index_i, sample_value_i, adc_reading_i
// result    out        empty_o / pop_i        drive_voltage_o .. voltage_ok_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// In the back end a sample beat reads the sum memory, then adds and writes back.
// A compute beat runs, per index, one restoring divide per sum set, both sets in parallel,
// then serial scans of the processed waveform for the peak and both half-maximum
// crossings over its single read port.
// Reset clears the sum valid bits, so all sums read as zero; no clearing pass is needed.
// A two-entry input queue keeps taking beats while the back end works, and the result
// register holds a finished result until popped while the back end moves on.
module pulse_average_peak_width_analyzer import apw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [IDX_W-1:0]       sample_index_i,
  input  logic [SAMPLE_BITS-1:0] sample_value_i,
  input  logic [ADC_W-1:0]       adc_reading_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [VOLT_W-1:0]      drive_voltage_o,
  output logic [SAMPLE_BITS-1:0] baseline_o,
  output logic [PROC_W-1:0]      amplitude_o,
  output logic [IDX_W-1:0]       pulse_width_o,
  output logic [IDX_W:0]         peak_position_o,
  output logic                   voltage_ok_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  logic    item_vld, item_take, res_vld;
  result_t res;

  // register writes are always taken; ready is tied high
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ped_count: CNT_W'(1), pulse_count: CNT_W'(1), subtract: 1'b0, drive: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PED_COUNT:   cfg_q.ped_count   <= cfg_data_i;
        REG_PULSE_COUNT: cfg_q.pulse_count <= cfg_data_i;
        REG_SUBTRACT:    cfg_q.subtract    <= cfg_data_i[0];
        REG_DRIVE:       cfg_q.drive       <= cfg_data_i[DRIVE_W-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // front: accept beats, drop unused commands, buffer for the back end
  apw_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o,
    .cmd_i, .idx_i(sample_index_i), .val_i(sample_value_i), .adc_i(adc_reading_i),
    .item_vld_o(item_vld), .item_o(item), .item_take_i(item_take)
  );

  // back: accumulate sums, run the compute sequence, hold the result
  apw_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_vld_i(item_vld), .item_i(item), .item_take_o(item_take),
    .res_vld_o(res_vld), .res_o(res), .res_pop_i(pop_i)
  );

  assign empty_o         = !res_vld;
  assign drive_voltage_o = res.volt;
  assign baseline_o      = res.base;
  assign amplitude_o     = res.amp;
  assign pulse_width_o   = res.width;
  assign peak_position_o = res.pos;
  assign voltage_ok_o    = res.ok;

endmodule
